// File: src/qts_pkg.sv
// Shared constants and types for the two-stack queue.
package qts_pkg;

    // Default stack depth
    localparam int DEPTH_DEF = 8;

    // Word width of queued data
    localparam int DATA_W = 32;

    // Operation codes carried on the input tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes carried on the output tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Per-cycle command to one stack
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

endpackage

// File: src/qts_stack.sv
// Bounded stack: word memory, fill count and the shared up/down count unit.
module qts_stack #(
    parameter int DEPTH = qts_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qts_pkg::t_stk_cmd                   i_cmd,
    input  logic signed [qts_pkg::DATA_W-1:0]   i_wdata,
    output logic signed [qts_pkg::DATA_W-1:0]   o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic signed [qts_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [qts_pkg::DATA_W-1:0] r_rdata;
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;
    logic [CW-1:0]                     w_step;
    logic [CW-1:0]                     w_sum;

    // One adder serves push (+1) and pop (-1)
    assign w_step  = i_cmd.pop ? {CW{1'b1}} : CW'(1);
    assign w_sum   = r_count + w_step;
    assign n_count = (i_cmd.push || i_cmd.pop) ? w_sum : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Push writes at the count, pop reads the top word
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= i_wdata;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[w_sum[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

// File: src/qts_ctrl.sv
// Sequencer: decodes operations, runs the stack-to-stack move, holds the result.
module qts_ctrl #(
    parameter int DEPTH = qts_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [$clog2(DEPTH+1)-1:0]          i_in_count,
    input  logic [$clog2(DEPTH+1)-1:0]          i_out_count,
    input  logic signed [qts_pkg::DATA_W-1:0]   i_out_rdata,
    output qts_pkg::t_stk_cmd                   o_in_cmd,
    output qts_pkg::t_stk_cmd                   o_out_cmd,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [qts_pkg::DATA_W-1:0]   o_data,
    output logic [1:0]                          o_status
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOVE = 4'b0010,
        S_POP  = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic                              r_pend, n_pend;
    logic signed [qts_pkg::DATA_W-1:0] r_data, n_data;
    logic [1:0]                        r_status, n_status;
    logic                              w_acc;

    assign w_acc = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_data    = r_data;
        n_status  = r_status;
        o_in_cmd  = '0;
        o_out_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_data = '0;
                    if (i_opcode == qts_pkg::OP_ENQ) begin
                        n_state = S_RESP;
                        if (i_in_count == CW'(DEPTH)) begin
                            n_status = qts_pkg::ST_OVERFLOW;
                        end else begin
                            o_in_cmd.push = 1'b1;
                            n_status      = qts_pkg::ST_OK;
                        end
                    end else if (i_out_count != '0) begin
                        o_out_cmd.pop = 1'b1;
                        n_state       = S_POP;
                    end else if (i_in_count != '0) begin
                        // start the move with the first read
                        o_in_cmd.pop = 1'b1;
                        n_pend       = 1'b1;
                        n_state      = S_MOVE;
                    end else begin
                        n_status = qts_pkg::ST_UNDERFLOW;
                        n_state  = S_RESP;
                    end
                end
            end
            S_MOVE: begin
                // write the word read last cycle, read the next one
                if (r_pend) begin
                    o_out_cmd.push = 1'b1;
                end
                if (i_in_count != '0) begin
                    o_in_cmd.pop = 1'b1;
                    n_pend       = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_out_cmd.pop = 1'b1;
                        n_state       = S_POP;
                    end
                end
            end
            S_POP: begin
                n_data   = i_out_rdata;
                n_status = qts_pkg::ST_OK;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_status <= n_status;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_RESP);
    assign o_data   = r_data;
    assign o_status = r_status;

endmodule

// File: src/queue_from_two_stacks.sv
// Top level of the first-in first-out queue built from two bounded stacks.
//
// The queue takes one operation per input transfer and returns exactly one
// result transfer for it. An enqueue (tuser 0) pushes tdata onto the input
// stack, or reports overflow when that stack already holds DEPTH words;
// words parked on the output stack do not add to that capacity. A dequeue
// (tuser 1) pops the output stack when it holds words, going through the
// pop state before the result state. When the output stack is empty, the
// sequencer first moves the whole input stack across one word per cycle,
// which reverses the order, and then pops. The move loop is bounded by the
// single read port of the input stack memory. A dequeue on an empty queue
// reports underflow with data 0. Each result then sits in an output
// register until taken; the block accepts the next operation once that
// result transfer has completed. Storage comes out of reset with zero fill
// counts and no memory clearing.
module queue_from_two_stacks #(
    parameter int DEPTH = qts_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // operation input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [qts_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] value
    input  logic                                s_axis_tuser,  // [0] opcode
    // result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [qts_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] data
    output logic [1:0]                          m_axis_tuser   // [1:0] status
);

    localparam int CW = $clog2(DEPTH + 1);

    qts_pkg::t_stk_cmd                 w_in_cmd;
    qts_pkg::t_stk_cmd                 w_out_cmd;
    logic signed [qts_pkg::DATA_W-1:0] w_in_rdata;
    logic signed [qts_pkg::DATA_W-1:0] w_out_rdata;
    logic [CW-1:0]                     w_in_count;
    logic [CW-1:0]                     w_out_count;

    // Input stack: fed straight from the input transfer
    qts_stack #(
        .DEPTH (DEPTH)
    ) u_in_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_in_cmd),
        .i_wdata (s_axis_tdata),
        .o_rdata (w_in_rdata),
        .o_count (w_in_count)
    );

    // Output stack: fed from the input stack's read port during a move
    qts_stack #(
        .DEPTH (DEPTH)
    ) u_out_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_out_cmd),
        .i_wdata (w_in_rdata),
        .o_rdata (w_out_rdata),
        .o_count (w_out_count)
    );

    qts_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_in_count  (w_in_count),
        .i_out_count (w_out_count),
        .i_out_rdata (w_out_rdata),
        .o_in_cmd    (w_in_cmd),
        .o_out_cmd   (w_out_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

    // Never take a new operation while a result is still held
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    // Fill counts stay within the stack depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_count <= CW'(DEPTH)) && (w_out_count <= CW'(DEPTH)))
        else $error("stack count beyond depth");

    // Error results carry zero data
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != qts_pkg::ST_OK)) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero data");

    // Underflow only when both stacks are empty
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == qts_pkg::ST_UNDERFLOW))
            |-> ((w_in_count == '0) && (w_out_count == '0)))
        else $error("underflow reported with words stored");

    // A move never pushes and pops the same stack in one cycle
    a_stack_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_cmd.push && w_in_cmd.pop) && !(w_out_cmd.push && w_out_cmd.pop))
        else $error("stack pushed and popped together");

endmodule

// File: tb/tb_queue_from_two_stacks.sv
// Self-checking testbench for the two-stack first-in first-out queue.
module tb_queue_from_two_stacks;

    localparam int DEPTH        = qts_pkg::DEPTH_DEF;
    localparam int DATA_W       = qts_pkg::DATA_W;
    localparam int RANDOM_OPS   = 750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int N_DIRECTED   = 23;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
    } t_result;

    // One row of the directed sequence; typed expectation used when has_exp is set
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] word;
        logic              has_exp;
        logic [DATA_W-1:0] exp_data;
        logic [1:0]        exp_status;
    } t_op_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [DATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
    logic                     s_axis_tuser = qts_pkg::OP_ENQ; // [0] opcode
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0] m_axis_tdata;        // [31:0] data
    logic [1:0]               m_axis_tuser;        // [1:0] status

    queue_from_two_stacks #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queue state as the testbench sees it
    logic [DATA_W-1:0] q_in_stk  [DEPTH];
    logic [DATA_W-1:0] q_out_stk [DEPTH];
    int                q_in_count  = 0;
    int                q_out_count = 0;

    t_result expected_results [$];
    int      error_count   = 0;
    int      cycle_count   = 0;
    bit      hold_off_req  = 1'b0;
    int      burst_left    = 0;
    bit      steady_sender = 1'b0;

    // Directed sequence: underflow on empty, fill with extreme words, overflow,
    // first dequeue reversing the input stack, then refill while the output
    // stack still holds words to show it adds no capacity.
    t_op_row directed_ops [N_DIRECTED] = '{
        '{qts_pkg::OP_DEQ, 32'h0000_0000, 1'b1, 32'h0000_0000, qts_pkg::ST_UNDERFLOW},
        '{qts_pkg::OP_ENQ, 32'h8000_0000, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h0000_0000, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h5555_5555, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h0000_0001, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h1234_5678, 1'b1, 32'h0000_0000, qts_pkg::ST_OVERFLOW},
        '{qts_pkg::OP_DEQ, 32'h0000_0000, 1'b1, 32'h8000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_DEQ, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'hC000_0000, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h3FFF_FFFF, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h0F0F_0F0F, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'hF0F0_F0F0, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h0000_8000, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h7FFF_0000, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h8000_0001, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_ENQ, 32'h0BAD_F00D, 1'b1, 32'h0000_0000, qts_pkg::ST_OVERFLOW},
        '{qts_pkg::OP_DEQ, 32'h0000_0000, 1'b0, 32'h0000_0000, qts_pkg::ST_OK},
        '{qts_pkg::OP_DEQ, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, qts_pkg::ST_OK}
    };

    // Advance the queue state by one operation and return the result it gives
    function automatic t_result predict_queue_result(logic op, logic [DATA_W-1:0] word);
        t_result r;
        r.data   = '0;
        r.status = qts_pkg::ST_OK;
        if (op == qts_pkg::OP_ENQ) begin
            if (q_in_count >= DEPTH) begin
                r.status = qts_pkg::ST_OVERFLOW;
            end else begin
                q_in_stk[q_in_count] = word;
                q_in_count++;
            end
        end else begin
            // refill the output stack only when it has run dry
            if (q_out_count == 0) begin
                while (q_in_count > 0 && q_out_count < DEPTH) begin
                    q_in_count--;
                    q_out_stk[q_out_count] = q_in_stk[q_in_count];
                    q_out_count++;
                end
            end
            if (q_out_count == 0) begin
                r.status = qts_pkg::ST_UNDERFLOW;
            end else begin
                q_out_count--;
                r.data = q_out_stk[q_out_count];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Offer one operation; return at the edge where the transfer completes.
    // Between bursts, drop tvalid for a random gap unless the sender runs steady.
    task automatic offer_op(logic op, logic [DATA_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            if (!steady_sender) begin
                gap = $urandom_range(8, 1);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(20, 1);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // Drop tvalid and wait until every outstanding result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Receiver: check each result transfer, then pick tready for the next cycle
    // from a rotating stall pattern, or hold off entirely when asked.
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age   = 0;
    int          hold_left     = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none pending", m_axis_tdata, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("data", m_axis_tdata, want.data);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", {30'b0, m_axis_tuser}, {30'b0, want.status});
            end
        end

        if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end

        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            // reload the pattern now and then; all-ones gives stall-free stretches
            if (pattern_age == 0) begin
                pattern_age = $urandom_range(96, 16);
                case ($urandom_range(3))
                    0:       stall_pattern = 16'hFFFF;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'h1111;
                    default: stall_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            pattern_age--;
            m_axis_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_result           pred;
        int                sent;
        int                seg_left;
        int                enq_pct;
        logic              op;
        logic [DATA_W-1:0] word;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_op(directed_ops[i].op, directed_ops[i].word);
            pred = predict_queue_result(directed_ops[i].op, directed_ops[i].word);
            if (directed_ops[i].has_exp)
                expected_results.push_back({directed_ops[i].exp_data,
                                            directed_ops[i].exp_status});
            else
                expected_results.push_back(pred);
        end
        drain_results();

        // Random part: segments that lean toward filling, emptying or neither,
        // so the stacks keep crossing their full and empty edges.
        sent     = 0;
        seg_left = 0;
        enq_pct  = 50;
        while (sent < RANDOM_OPS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 10);
                case ($urandom_range(2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
                steady_sender = ($urandom_range(3) == 0);
            end
            seg_left--;

            // long receiver hold-off while the sender keeps offering
            if (sent == RANDOM_OPS / 3)
                hold_off_req = 1'b1;
            // sender pause until the block has returned everything
            if (sent == (2 * RANDOM_OPS) / 3)
                drain_results();

            op   = ($urandom_range(99) < enq_pct) ? qts_pkg::OP_ENQ : qts_pkg::OP_DEQ;
            word = $urandom;
            offer_op(op, word);
            pred = predict_queue_result(op, word);
            expected_results.push_back(pred);
            sent++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
src/qts_pkg.sv
src/qts_stack.sv
src/qts_ctrl.sv
src/queue_from_two_stacks.sv
tb/tb_queue_from_two_stacks.sv
